>>> rtl/npdf_pkg.sv
// Shared constants, codes and types of the nearest point distance field block.
`default_nettype none
package npdf_pkg;

    localparam int MAX_POINTS      = 256;
    localparam int GRID_INDEX_BITS = 10;

    localparam int COORD_W   = 20;
    localparam int STEP_W    = 16;
    localparam int ADDR_W    = $clog2(MAX_POINTS);
    localparam int CNT_W     = $clog2(MAX_POINTS + 1);
    localparam int NODE_W    = ((GRID_INDEX_BITS + STEP_W) > COORD_W ?
                                (GRID_INDEX_BITS + STEP_W) : COORD_W) + 2;
    localparam int DIFF_W    = NODE_W + 1;
    localparam int MUL_W     = NODE_W;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int SUM_W     = PROD_W + 1;
    localparam int BEST_W    = 28;
    localparam int DIST_W    = 14;
    localparam int STAT_W    = 1;
    localparam int REQ_W     = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = COORD_W;

    localparam int SQRT_STEPS = BEST_W / 2;
    localparam int SQ_CNT_W   = $clog2(SQRT_STEPS + 1);

    localparam logic [BEST_W-1:0] DIST2_CAP = BEST_W'(256000000);

    localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(320);

    localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_APPEND = 2'd1;
    localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_X   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_Y   = 2'd3;

    localparam logic [STAT_W-1:0] STATUS_OK   = 1'b0;
    localparam logic [STAT_W-1:0] STATUS_FULL = 1'b1;

    typedef struct packed {
        logic              done;
        logic [DIST_W-1:0] root;
    } t_sqrt_sts;

endpackage
`default_nettype wire

>>> rtl/npdf_store.sv
// Point store memory with one write port and one registered read port.
`default_nettype none
module npdf_store
    import npdf_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_wr_en,
    input  wire logic [ADDR_W-1:0]         i_wr_addr,
    input  wire logic signed [COORD_W-1:0] i_wr_x,
    input  wire logic signed [COORD_W-1:0] i_wr_y,
    input  wire logic                      i_rd_en,
    input  wire logic [ADDR_W-1:0]         i_rd_addr,
    output logic signed [COORD_W-1:0]      o_rd_x,
    output logic signed [COORD_W-1:0]      o_rd_y
);

    logic signed [COORD_W-1:0] r_mem_x [MAX_POINTS];
    logic signed [COORD_W-1:0] r_mem_y [MAX_POINTS];
    logic signed [COORD_W-1:0] r_rd_x;
    logic signed [COORD_W-1:0] r_rd_y;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem_x[i_wr_addr] <= i_wr_x;
            r_mem_y[i_wr_addr] <= i_wr_y;
        end
        if (i_rd_en) begin
            r_rd_x <= r_mem_x[i_rd_addr];
            r_rd_y <= r_mem_y[i_rd_addr];
        end
    end

    assign o_rd_x = r_rd_x;
    assign o_rd_y = r_rd_y;

endmodule
`default_nettype wire

>>> rtl/npdf_isqrt.sv
// Iterative integer square root, one result bit per cycle.
`default_nettype none
module npdf_isqrt
    import npdf_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [BEST_W-1:0] i_value,
    output t_sqrt_sts              o_sts
);

    logic                r_busy;
    logic                r_done;
    logic [SQ_CNT_W-1:0] r_cnt;
    logic [BEST_W-1:0]   r_rem;
    logic [BEST_W-1:0]   r_res;
    logic [BEST_W-1:0]   r_bit;
    logic [BEST_W:0]     trial;
    logic                fits;

    assign trial = {1'b0, r_res} + {1'b0, r_bit};
    assign fits  = ({1'b0, r_rem} >= trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == SQ_CNT_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= SQ_CNT_W'(SQRT_STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - SQ_CNT_W'(1);
                if (r_cnt == SQ_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_value;
            r_res <= '0;
            r_bit <= BEST_W'(1) << (BEST_W - 2);
        end else if (r_busy) begin
            if (fits) begin
                r_rem <= r_rem - trial[BEST_W-1:0];
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_sts.done = r_done;
    assign o_sts.root = r_res[DIST_W-1:0];

endmodule
`default_nettype wire

>>> rtl/nearest_point_distance_field_top.sv
// Top level of the nearest point distance field: sequencer, shared multiplier and I/O.
`default_nettype none
// Keeps up to 256 target points and answers distance queries for grid nodes at
// origin plus index times step, in 1/16 units. A clear or an append goes straight
// to the output state, which loads its result into the output register, and the
// block then returns to idle for the next transaction. A query walks the stored
// points one at a time through a single shared multiplier (after the node x and y
// are formed, the squares of a point's x and y differences are formed in turn and
// summed into a running minimum), then runs a 14-step square root and loads the
// root into the output register; the next transaction is accepted back in idle.
// The input is not ready while an item is being processed; the result sits in an
// output register until it is taken, and a result that is not taken holds the block.
module nearest_point_distance_field_top
    import npdf_pkg::*;
(
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]          i_cfg_index,
    input  wire logic [CFG_W-1:0]              i_cfg_data,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [REQ_W-1:0]              i_req_type,
    input  wire logic signed [COORD_W-1:0]     i_point_x,
    input  wire logic signed [COORD_W-1:0]     i_point_y,
    input  wire logic                          i_point_is_target,
    input  wire logic [GRID_INDEX_BITS-1:0]    i_grid_ix,
    input  wire logic [GRID_INDEX_BITS-1:0]    i_grid_iy,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [DIST_W-1:0]                  o_distance,
    output logic [STAT_W-1:0]                  o_status,
    output logic [CNT_W-1:0]                   o_points_held
);

    localparam int ST_W = 4;
    localparam logic [ST_W-1:0] S_IDLE      = 4'd0;
    localparam logic [ST_W-1:0] S_NX        = 4'd1;
    localparam logic [ST_W-1:0] S_NY        = 4'd2;
    localparam logic [ST_W-1:0] S_NYADD     = 4'd3;
    localparam logic [ST_W-1:0] S_DIFF      = 4'd4;
    localparam logic [ST_W-1:0] S_SQX       = 4'd5;
    localparam logic [ST_W-1:0] S_SQY       = 4'd6;
    localparam logic [ST_W-1:0] S_ACC       = 4'd7;
    localparam logic [ST_W-1:0] S_ROOT_GO   = 4'd8;
    localparam logic [ST_W-1:0] S_ROOT_WAIT = 4'd9;
    localparam logic [ST_W-1:0] S_OUT       = 4'd10;

    logic [ST_W-1:0]              r_state;
    logic [ST_W-1:0]              n_state;
    logic signed [COORD_W-1:0]    r_origin_x;
    logic signed [COORD_W-1:0]    r_origin_y;
    logic [STEP_W-1:0]            r_step_x;
    logic [STEP_W-1:0]            r_step_y;
    logic [CNT_W-1:0]             r_count;
    logic [CNT_W-1:0]             n_count;
    logic [CNT_W-1:0]             r_idx;
    logic [GRID_INDEX_BITS-1:0]   r_ix;
    logic [GRID_INDEX_BITS-1:0]   r_iy;
    logic signed [NODE_W-1:0]     r_nx;
    logic signed [NODE_W-1:0]     r_ny;
    logic [MUL_W-1:0]             r_ax;
    logic [MUL_W-1:0]             r_ay;
    logic [PROD_W-1:0]            r_prod;
    logic [PROD_W-1:0]            r_acc;
    logic [BEST_W-1:0]            r_best;
    logic [DIST_W-1:0]            r_dist;
    logic [STAT_W-1:0]            r_stat;
    logic [STAT_W-1:0]            n_stat;
    logic                         r_out_valid;
    logic [DIST_W-1:0]            r_out_dist;
    logic [STAT_W-1:0]            r_out_stat;
    logic [CNT_W-1:0]             r_out_held;

    logic                         in_fire;
    logic                         out_load;
    logic                         wr_en;
    logic                         rd_en;
    logic [ADDR_W-1:0]            rd_addr;
    logic [CNT_W-1:0]             idx_next;
    logic                         more;
    logic signed [COORD_W-1:0]    rd_x;
    logic signed [COORD_W-1:0]    rd_y;
    logic signed [DIFF_W-1:0]     dx;
    logic signed [DIFF_W-1:0]     dy;
    logic [DIFF_W-1:0]            abs_x;
    logic [DIFF_W-1:0]            abs_y;
    logic [MUL_W-1:0]             mul_a;
    logic [MUL_W-1:0]             mul_b;
    logic [SUM_W-1:0]             d2;
    logic signed [NODE_W-1:0]     node_sum;
    logic signed [NODE_W-1:0]     node_org;
    logic                         sq_start;
    t_sqrt_sts                    sq_sts;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;
    assign out_load   = (r_state == S_OUT) && (!r_out_valid || i_out_ready);
    assign wr_en      = in_fire && (i_req_type == REQ_APPEND) && i_point_is_target &&
                        (r_count < CNT_W'(MAX_POINTS));
    assign idx_next   = r_idx + CNT_W'(1);
    assign more       = (idx_next < r_count);
    assign rd_en      = (r_state == S_NYADD) || (r_state == S_ACC);
    assign rd_addr    = (r_state == S_NYADD) ? '0 : idx_next[ADDR_W-1:0];
    assign sq_start   = (r_state == S_ROOT_GO);

    npdf_store u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_count[ADDR_W-1:0]),
        .i_wr_x    (i_point_x),
        .i_wr_y    (i_point_y),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_x    (rd_x),
        .o_rd_y    (rd_y)
    );

    npdf_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_value (r_best),
        .o_sts   (sq_sts)
    );

    assign dx = {{(DIFF_W-NODE_W){r_nx[NODE_W-1]}}, r_nx} -
                {{(DIFF_W-COORD_W){rd_x[COORD_W-1]}}, rd_x};
    assign dy = {{(DIFF_W-NODE_W){r_ny[NODE_W-1]}}, r_ny} -
                {{(DIFF_W-COORD_W){rd_y[COORD_W-1]}}, rd_y};
    assign abs_x = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
    assign abs_y = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);

    always_comb begin
        case (r_state)
            S_NX: begin
                mul_a = MUL_W'(r_ix);
                mul_b = MUL_W'(r_step_x);
            end
            S_NY: begin
                mul_a = MUL_W'(r_iy);
                mul_b = MUL_W'(r_step_y);
            end
            S_SQX: begin
                mul_a = r_ax;
                mul_b = r_ax;
            end
            S_SQY: begin
                mul_a = r_ay;
                mul_b = r_ay;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign node_org = (r_state == S_NY) ?
                      {{(NODE_W-COORD_W){r_origin_x[COORD_W-1]}}, r_origin_x} :
                      {{(NODE_W-COORD_W){r_origin_y[COORD_W-1]}}, r_origin_y};
    assign node_sum = node_org + $signed({1'b0, r_prod[NODE_W-2:0]});
    assign d2       = {1'b0, r_acc} + {1'b0, r_prod};

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_stat  = r_stat;
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_stat = STATUS_OK;
                    case (i_req_type)
                        REQ_CLEAR: begin
                            n_count = '0;
                            n_state = S_OUT;
                        end
                        REQ_APPEND: begin
                            if (wr_en) begin
                                n_count = r_count + CNT_W'(1);
                            end else if (i_point_is_target) begin
                                n_stat = STATUS_FULL;
                            end
                            n_state = S_OUT;
                        end
                        REQ_QUERY: n_state = S_NX;
                        default:   n_state = S_OUT;
                    endcase
                end
            end
            S_NX:    n_state = S_NY;
            S_NY:    n_state = S_NYADD;
            S_NYADD: n_state = (r_count == '0) ? S_ROOT_GO : S_DIFF;
            S_DIFF:  n_state = S_SQX;
            S_SQX:   n_state = S_SQY;
            S_SQY:   n_state = S_ACC;
            S_ACC:   n_state = more ? S_DIFF : S_ROOT_GO;
            S_ROOT_GO: n_state = S_ROOT_WAIT;
            S_ROOT_WAIT: begin
                if (sq_sts.done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_stat      <= STATUS_OK;
            r_out_valid <= 1'b0;
            r_origin_x  <= '0;
            r_origin_y  <= '0;
            r_step_x    <= STEP_RESET;
            r_step_y    <= STEP_RESET;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_stat  <= n_stat;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_ORIGIN_X: r_origin_x <= i_cfg_data;
                    REG_ORIGIN_Y: r_origin_y <= i_cfg_data;
                    REG_STEP_X:   r_step_x   <= i_cfg_data[STEP_W-1:0];
                    REG_STEP_Y:   r_step_y   <= i_cfg_data[STEP_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(mul_a * mul_b);
        case (r_state)
            S_IDLE: begin
                r_ix   <= i_grid_ix;
                r_iy   <= i_grid_iy;
                r_dist <= '0;
                r_best <= DIST2_CAP;
            end
            S_NY:    r_nx <= node_sum;
            S_NYADD: begin
                r_ny  <= node_sum;
                r_idx <= '0;
            end
            S_DIFF: begin
                r_ax <= abs_x[MUL_W-1:0];
                r_ay <= abs_y[MUL_W-1:0];
            end
            S_SQY:   r_acc <= r_prod;
            S_ACC: begin
                if (d2 < SUM_W'(r_best)) begin
                    r_best <= d2[BEST_W-1:0];
                end
                r_idx <= idx_next;
            end
            S_ROOT_WAIT: begin
                if (sq_sts.done) begin
                    r_dist <= sq_sts.root;
                end
            end
            default: ;
        endcase
        if (out_load) begin
            r_out_dist <= r_dist;
            r_out_stat <= r_stat;
            r_out_held <= r_count;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_distance    = r_out_dist;
    assign o_status      = r_out_stat;
    assign o_points_held = r_out_held;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_POINTS))
        else $error("point count exceeds the store depth");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> !o_in_ready)
        else $error("input ready right after a transaction was accepted");

    a_root_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sq_sts.done |-> (r_state == S_ROOT_WAIT))
        else $error("square root finished outside its wait state");

    a_best_capped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ACC) |=> (r_best <= DIST2_CAP))
        else $error("running minimum rose above the cap");

    a_count_stable_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ACC) |=> $stable(r_count))
        else $error("point count changed during a query");
`endif

endmodule
`default_nettype wire
